### src/rssw_pkg.sv
// Shared types, codes and constants for the range subset sorted window block.
`default_nettype none
package rssw_pkg;

  localparam int MAX_ITEMS_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int BOUND_W         = 40;
  localparam int IN_W            = 32;
  localparam int NUM_W           = 6;
  localparam int KIND_W          = 2;
  localparam int APB_AW          = 4;
  localparam int APB_DW          = 64;

  localparam logic [KIND_W-1:0] KIND_SIZE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INDEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PREFIX,
    S_KHI_RD,
    S_KHI_EV,
    S_KLO_RD,
    S_KLO_EV,
    S_WIN_RD,
    S_WIN_EV,
    S_MASK_RD,
    S_MASK_SET,
    S_EMIT_SIZE,
    S_SCAN,
    S_EMIT_NONE
  } state_t;

  typedef enum logic [1:0] {
    RD_KHIGH,
    RD_KLOW,
    RD_WIN,
    RD_ORIGIN
  } rd_sel_t;

  typedef enum logic [1:0] {
    OUT_SIZE,
    OUT_IDX,
    OUT_NONE
  } out_sel_t;

  typedef struct packed {
    logic     ins;
    logic     pre_step;
    logic     k_init;
    logic     k_inc;
    logic     i_init;
    logic     i_inc;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     mj_init;
    logic     mj_inc;
    logic     mask_set;
    logic     sj_init;
    logic     sj_inc;
    logic     out_load;
    out_sel_t out_sel;
    logic     batch_clr;
  } cmd_t;

  typedef struct packed {
    logic last_pre;
    logic above_high;
    logic below_low;
    logic k_last;
    logic i_last;
    logic mj_last;
    logic bit_set;
    logic bit_final;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

### src/rssw_regs.sv
// Bound registers behind the APB-style configuration port.
`default_nettype none
module rssw_regs
  import rssw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic     [BOUND_W-1:0] low_bound,
  output logic     [BOUND_W-1:0] high_bound
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound  <= '0;
      high_bound <= '0;
    end else if (wr) begin
      if (paddr[3]) begin
        high_bound <= pwdata[BOUND_W-1:0];
      end else begin
        low_bound <= pwdata[BOUND_W-1:0];
      end
    end
  end

  assign prdata = paddr[3] ? APB_DW'(high_bound) : APB_DW'(low_bound);

endmodule
`default_nettype wire

### src/rssw_ctrl.sv
// Sequencer for loading, prefix build, window search and result emission.
`default_nettype none
module rssw_ctrl
  import rssw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    last_item,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_KHIGH;
    cmd.out_sel = OUT_SIZE;
    in_ready   = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ins = 1'b1;
          if (last_item) begin
            state_next = S_PREFIX;
          end
        end
      end
      S_PREFIX: begin
        cmd.pre_step = 1'b1;
        if (st.last_pre) begin
          cmd.k_init = 1'b1;
          state_next = S_KHI_RD;
        end
      end
      S_KHI_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_KHIGH;
        state_next = S_KHI_EV;
      end
      S_KHI_EV: begin
        if (st.above_high) begin
          if (st.k_last) begin
            state_next = S_EMIT_NONE;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_KHI_RD;
          end
        end else begin
          state_next = S_KLO_RD;
        end
      end
      S_KLO_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_KLOW;
        state_next = S_KLO_EV;
      end
      S_KLO_EV: begin
        if (st.below_low) begin
          if (st.k_last) begin
            state_next = S_EMIT_NONE;
          end else begin
            cmd.k_inc  = 1'b1;
            state_next = S_KHI_RD;
          end
        end else begin
          cmd.i_init = 1'b1;
          state_next = S_WIN_RD;
        end
      end
      S_WIN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_WIN;
        state_next = S_WIN_EV;
      end
      S_WIN_EV: begin
        if (!st.below_low && !st.above_high) begin
          cmd.mj_init = 1'b1;
          state_next  = S_MASK_RD;
        end else if (!st.i_last) begin
          cmd.i_inc  = 1'b1;
          state_next = S_WIN_RD;
        end else if (st.k_last) begin
          state_next = S_EMIT_NONE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_KHI_RD;
        end
      end
      S_MASK_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ORIGIN;
        state_next = S_MASK_SET;
      end
      S_MASK_SET: begin
        cmd.mask_set = 1'b1;
        if (st.mj_last) begin
          cmd.sj_init = 1'b1;
          state_next  = S_EMIT_SIZE;
        end else begin
          cmd.mj_inc = 1'b1;
          state_next = S_MASK_RD;
        end
      end
      S_EMIT_SIZE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_SIZE;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!st.bit_set) begin
          cmd.sj_inc = 1'b1;
        end else if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_IDX;
          cmd.sj_inc   = 1'b1;
          if (st.bit_final) begin
            cmd.batch_clr = 1'b1;
            state_next    = S_LOAD;
          end
        end
      end
      S_EMIT_NONE: begin
        if (!st.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_NONE;
          cmd.batch_clr = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/rssw_dp.sv
// Datapath: sorted insert row, prefix sum and origin memories, mask and result register.
`default_nettype none
module rssw_dp
  import rssw_pkg::*;
#(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [IN_W-1:0]    item_value,
  input  wire logic [BOUND_W-1:0] low_bound,
  input  wire logic [BOUND_W-1:0] high_bound,
  input  wire cmd_t               cmd,
  output status_t                 st,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [KIND_W-1:0]       result_kind,
  output logic [NUM_W-1:0]        result_number,
  output logic                    end_of_run
);

  localparam int AW    = $clog2(MAX_ITEMS + 1);
  localparam int OAW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int SUM_W = VALUE_WIDTH + AW;
  localparam int CMP_W = (SUM_W > BOUND_W) ? SUM_W : BOUND_W;

  logic [VALUE_WIDTH-1:0] vals [MAX_ITEMS];
  logic [OAW-1:0]         orig [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]   sel;
  logic [VALUE_WIDTH-1:0] v;
  logic                   do_ins;

  logic [AW-1:0]    count, p, k, i, mj;
  logic [OAW-1:0]   sj;
  logic [SUM_W-1:0] acc, acc_next;
  logic [SUM_W-1:0] pmem [MAX_ITEMS + 1];
  logic [OAW-1:0]   omem [MAX_ITEMS];
  logic [SUM_W-1:0] pa_q, pb_q, diff;
  logic [OAW-1:0]   orig_q;
  logic [AW-1:0]    addr_a, addr_b;
  logic [MAX_ITEMS-1:0] mask, mask_rest;

  assign v      = VALUE_WIDTH'(item_value);
  assign do_ins = cmd.ins && (count < AW'(MAX_ITEMS));

  always_comb begin
    for (int n = 0; n < MAX_ITEMS; n++) begin
      sel[n] = (AW'(n) < count) ? (vals[n] > v) : 1'b1;
    end
  end

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_row
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (sel[g]) begin
          if (g > 0 && sel[(g > 0) ? g - 1 : 0]) begin
            vals[g] <= vals[(g > 0) ? g - 1 : 0];
            orig[g] <= orig[(g > 0) ? g - 1 : 0];
          end else begin
            vals[g] <= v;
            orig[g] <= count[OAW-1:0];
          end
        end
      end else if (cmd.pre_step) begin
        if (g < MAX_ITEMS - 1) begin
          vals[g] <= vals[(g < MAX_ITEMS - 1) ? g + 1 : g];
          orig[g] <= orig[(g < MAX_ITEMS - 1) ? g + 1 : g];
        end
      end
    end
  end

  assign acc_next = acc + SUM_W'(vals[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.batch_clr) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      p   <= '0;
      acc <= '0;
    end else if (cmd.pre_step) begin
      p   <= p + AW'(1);
      acc <= acc_next;
      pmem[p + AW'(1)] <= acc_next;
      omem[p[OAW-1:0]] <= orig[0];
    end
    if (cmd.k_init) begin
      k <= AW'(1);
    end else if (cmd.k_inc) begin
      k <= k + AW'(1);
    end
    if (cmd.i_init) begin
      i <= k;
    end else if (cmd.i_inc) begin
      i <= i + AW'(1);
    end
    if (cmd.mj_init) begin
      mj <= i - k;
    end else if (cmd.mj_inc) begin
      mj <= mj + AW'(1);
    end
    if (cmd.sj_init) begin
      sj <= '0;
    end else if (cmd.sj_inc) begin
      sj <= sj + OAW'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_KHIGH: begin
        addr_a = k;
        addr_b = '0;
      end
      RD_KLOW: begin
        addr_a = count;
        addr_b = count - k;
      end
      RD_WIN: begin
        addr_a = i;
        addr_b = i - k;
      end
      default: begin
        addr_a = mj;
        addr_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pa_q   <= (addr_a == '0) ? '0 : pmem[addr_a];
      pb_q   <= (addr_b == '0) ? '0 : pmem[addr_b];
      orig_q <= omem[mj[OAW-1:0]];
    end
  end

  assign diff = pa_q - pb_q;

  always_comb begin
    mask_rest     = mask;
    mask_rest[sj] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.mj_init) begin
      mask <= '0;
    end else if (cmd.mask_set) begin
      mask[orig_q] <= 1'b1;
    end else if (cmd.out_load && cmd.out_sel == OUT_IDX) begin
      mask <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_SIZE: begin
          result_kind   <= KIND_SIZE;
          result_number <= NUM_W'(k);
          end_of_run    <= 1'b0;
        end
        OUT_IDX: begin
          result_kind   <= KIND_INDEX;
          result_number <= NUM_W'(sj) + NUM_W'(1);
          end_of_run    <= (mask_rest == '0);
        end
        default: begin
          result_kind   <= KIND_NONE;
          result_number <= '0;
          end_of_run    <= 1'b1;
        end
      endcase
    end
  end

  assign st.last_pre   = (p == count - AW'(1));
  assign st.above_high = CMP_W'(diff) > CMP_W'(high_bound);
  assign st.below_low  = CMP_W'(diff) < CMP_W'(low_bound);
  assign st.k_last     = (k == count);
  assign st.i_last     = (i == count);
  assign st.mj_last    = (mj == i - AW'(1));
  assign st.bit_set    = mask[sj];
  assign st.bit_final  = (mask_rest == '0);
  assign st.out_busy   = out_valid && !out_ready;

endmodule
`default_nettype wire

### src/range_subset_sorted_window.sv
// Top level of the range subset sorted window block.
// Values load one per cycle while the block is loading; each of the first
// MAX_ITEMS is inserted into a sorted register row in the cycle it is
// accepted, later ones are dropped. The request that carries last_item starts
// the search, and no new value is taken until the answer is out. The search
// builds prefix sums, then tests each size k, from one up, with a read and
// an evaluate state per test: the k smallest against high_bound, the k largest
// against low_bound when that passes, then each window of k in turn. All sums
// come from one prefix-sum memory read at two addresses per cycle. A found
// answer gathers the window's indices into a mask, emits the size result, then
// scans the indices out, one result per cycle at most while out_ready holds.
`default_nettype none
module range_subset_sorted_window
  import rssw_pkg::*;
#(
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   item_value,
  input  wire logic              last_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      result_kind,
  output logic [NUM_W-1:0]       result_number,
  output logic                   end_of_run,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [BOUND_W-1:0] low_bound, high_bound;
  cmd_t               cmd;
  status_t            st;

  rssw_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .low_bound  (low_bound),
    .high_bound (high_bound)
  );

  rssw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_item (last_item),
    .in_ready  (in_ready),
    .st        (st),
    .cmd       (cmd)
  );

  rssw_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item_value    (item_value),
    .low_bound     (low_bound),
    .high_bound    (high_bound),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .result_number (result_number),
    .end_of_run    (end_of_run)
  );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for range_subset_sorted_window: directed and random batches checked against a subset-window predictor.
`default_nettype none
module tb_top;
  import rssw_pkg::*;

  typedef struct packed {
    logic [IN_W-1:0] value;
    logic            last;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [NUM_W-1:0]  number;
    logic              eor;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] item_value = '0;
  logic last_item = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] result_kind;
  logic [NUM_W-1:0] result_number;
  logic end_of_run;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  localparam logic [APB_AW-1:0] ADDR_LOW  = 4'd0;
  localparam logic [APB_AW-1:0] ADDR_HIGH = 4'd8;

  range_subset_sorted_window DUT (.*);

  always #4 clk = ~clk;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  bit       no_idle = 1'b0;
  bit       hold_send = 1'b0;

  logic [BOUND_W-1:0] low_bound_q = '0;
  logic [BOUND_W-1:0] high_bound_q = '0;
  logic [31:0]        batch_values[MAX_ITEMS_DEF];
  logic [NUM_W-1:0]   batch_origin[MAX_ITEMS_DEF];
  int                 batch_count = 0;

  task automatic add_answer(answer_t a);
    expected_answers.insert(expected_answers.size(), a);
  endtask

  task automatic add_request(request_t r);
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic predict_request(request_t r);
    logic [BOUND_W-1:0] sums[MAX_ITEMS_DEF+1];
    logic [BOUND_W-1:0] s;
    logic [MAX_ITEMS_DEF-1:0] mask;
    int pos;
    int n;
    bit found;
    if (batch_count < MAX_ITEMS_DEF) begin
      pos = batch_count;
      while (pos > 0 && batch_values[pos-1] > r.value) begin
        batch_values[pos] = batch_values[pos-1];
        batch_origin[pos] = batch_origin[pos-1];
        pos--;
      end
      batch_values[pos] = r.value;
      batch_origin[pos] = NUM_W'(batch_count + 1);
      batch_count++;
    end
    if (!r.last) return;
    n = batch_count;
    found = 1'b0;
    sums[0] = '0;
    for (int i = 1; i <= n; i++) sums[i] = sums[i-1] + BOUND_W'(batch_values[i-1]);
    for (int k = 1; k <= n && !found; k++) begin
      if (sums[k] > high_bound_q || sums[n] - sums[n-k] < low_bound_q) continue;
      for (int i = k; i <= n && !found; i++) begin
        s = sums[i] - sums[i-k];
        if (s < low_bound_q || s > high_bound_q) continue;
        found = 1'b1;
        mask = '0;
        for (int j = i - k; j < i; j++) mask[batch_origin[j]-1] = 1'b1;
        add_answer(answer_t'{KIND_SIZE, NUM_W'(k), 1'b0});
        for (int j = 0; j < MAX_ITEMS_DEF; j++)
          if (mask[j]) add_answer(answer_t'{KIND_INDEX, NUM_W'(j + 1), 1'b0});
        expected_answers[$].eor = 1'b1;
      end
    end
    if (!found) add_answer(answer_t'{KIND_NONE, '0, 1'b1});
    batch_count = 0;
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_request('{item_value, last_item});
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (!hold_send && pending_requests.size() > 0) begin
          {item_value, last_item} <= pending_requests.pop_front();
          in_valid <= 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall = 0;
  answer_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result kind=%0d number=%0d", result_kind, result_number);
          mismatches++;
        end else begin
          want = expected_answers.pop_front();
          if (result_kind !== want.kind) begin
            $error("result_kind expected %0d actual %0d", want.kind, result_kind);
            mismatches++;
          end
          if (result_number !== want.number) begin
            $error("result_number expected %0d actual %0d", want.number, result_number);
            mismatches++;
          end
          if (end_of_run !== want.eor) begin
            $error("end_of_run expected %0d actual %0d", want.eor, end_of_run);
            mismatches++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_bound(logic [APB_AW-1:0] addr, logic [BOUND_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LOW) low_bound_q = value;
    else high_bound_q = value;
  endtask

  task automatic drain_answers();
    while (pending_requests.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic queue_batch(int n, int value_mode);
    logic [IN_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      case (value_mode)
        0: v = $urandom_range(0, 15);
        1: v = $urandom_range(0, 1000);
        2: v = $urandom;
        default: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
      add_request(request_t'{v, i == n - 1});
    end
  endtask

  task automatic random_bounds();
    logic [BOUND_W-1:0] a;
    logic [BOUND_W-1:0] b;
    case ($urandom_range(0, 4))
      0: begin
        a = BOUND_W'($urandom_range(0, 60));
        b = a + BOUND_W'($urandom_range(0, 40));
      end
      1: begin
        a = BOUND_W'($urandom_range(0, 3000));
        b = a + BOUND_W'($urandom_range(0, 2000));
      end
      2: begin
        a = BOUND_W'({$urandom, $urandom});
        b = BOUND_W'({$urandom, $urandom});
      end
      3: begin
        a = BOUND_W'($urandom_range(100, 200));
        b = BOUND_W'($urandom_range(0, 99));
      end
      default: begin a = '0; b = '1; end
    endcase
    write_bound(ADDR_LOW, a);
    write_bound(ADDR_HIGH, b);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, overflow, empty range
    write_bound(ADDR_LOW, '0);
    write_bound(ADDR_HIGH, '1);
    add_request(request_t'{32'hFFFF_FFFF, 1'b0});
    add_request(request_t'{32'h0, 1'b0});
    add_request(request_t'{32'hFFFF_FFFF, 1'b1});
    add_request(request_t'{32'h0, 1'b1});
    drain_answers();
    write_bound(ADDR_LOW, 40'd10);
    write_bound(ADDR_HIGH, 40'd12);
    for (int i = 0; i < 34; i++) add_request(request_t'{32'(i % 5), i == 33});
    drain_answers();
    write_bound(ADDR_LOW, 40'd20);
    write_bound(ADDR_HIGH, 40'd5);
    queue_batch(4, 0);
    drain_answers();
    write_bound(ADDR_LOW, '1);
    write_bound(ADDR_HIGH, '1);
    queue_batch(3, 3);
    drain_answers();
    // random batches
    for (int b = 0; b < 57; b++) begin
      random_bounds();
      queue_batch($urandom_range(0, 9) == 0 ? $urandom_range(20, 36) : $urandom_range(1, 8),
                  $urandom_range(0, 3));
      if (b == 20) begin
        while (pending_requests.size() > 0 || in_valid) @(posedge clk);
        hold_send = 1'b1;
        queue_batch(3, 1);
        while (expected_answers.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      if (b == 48) no_idle = 1'b1;
      drain_answers();
    end
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
src/rssw_pkg.sv
src/rssw_regs.sv
src/rssw_ctrl.sv
src/rssw_dp.sv
src/range_subset_sorted_window.sv
tb/tb_top.sv
